[rtl/drd3_pkg.sv]
// Package for the 3x3 directional ridge detector: default sizes, register
// indexes, reset values and the per-item control word passed between stages.
// No dependencies.
`default_nettype none

package drd3_pkg;

  localparam int MAX_LINE_WIDTH_DEF   = 1024;
  localparam int MAX_PLANE_HEIGHT_DEF = 1024;
  localparam int SAMPLE_BITS_DEF      = 16;

  // Configuration port layout.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 15;
  localparam int SIZE_BITS      = 11;
  localparam int THR_BITS       = 15;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PLANE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD    = 2'd2;

  // Input transaction kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  localparam logic [SIZE_BITS-1:0] LINE_WIDTH_RST   = 11'd200;
  localparam logic [SIZE_BITS-1:0] PLANE_HEIGHT_RST = 11'd200;
  localparam logic [THR_BITS-1:0]  THRESHOLD_RST    = 15'd41;

  // Result queue depth; covers the one item in flight plus output stalls.
  localparam int OUT_QUEUE_DEPTH = 4;

  // Window control for one item, decided at acceptance time.
  typedef struct packed {
    logic emit;     // item completes a centre
    logic eop;      // that centre is the last of the plane
    logic col0;     // item sits in column zero
    logic col1;     // item sits in column one
    logic narrow;   // line width is one pixel
    logic top_ok;   // upper line store holds a row of this plane
    logic mid_ok;   // middle line store holds a row of this plane
  } win_ctrl_t;

endpackage

`default_nettype wire

[rtl/drd3_if.sv]
// Channel interfaces of the ridge detector: input samples, results and the
// configuration write channel. Depends on drd3_pkg.
`default_nettype none

interface drd3_in_if #(
  parameter int SAMPLE_BITS = drd3_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output kind, output sample, input ready);
  modport sink   (input valid, input kind, input sample, output ready);
endinterface

interface drd3_out_if #(
  parameter int SAMPLE_BITS = drd3_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] ridge_value;
  logic                          is_ridge;
  logic                          end_of_plane;

  modport source (output valid, output ridge_value, output is_ridge,
                  output end_of_plane, input ready);
  modport sink   (input valid, input ridge_value, input is_ridge,
                  input end_of_plane, output ready);
endinterface

interface drd3_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [drd3_pkg::CFG_INDEX_BITS-1:0]   index;
  logic [drd3_pkg::CFG_DATA_BITS-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/drd3_ctrl.sv]
// Configuration registers, raster position tracking and the input stage
// register of the ridge detector. Depends on drd3_pkg and drd3_if.
`default_nettype none

module drd3_ctrl #(
  parameter int MAX_LINE_WIDTH   = drd3_pkg::MAX_LINE_WIDTH_DEF,
  parameter int MAX_PLANE_HEIGHT = drd3_pkg::MAX_PLANE_HEIGHT_DEF,
  parameter int SAMPLE_BITS      = drd3_pkg::SAMPLE_BITS_DEF,
  parameter int COL_BITS         = $clog2(MAX_LINE_WIDTH)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  drd3_in_if.sink                             in_bus,
  drd3_cfg_if.sink                            cfg_bus,
  input  wire logic                           room,
  output      logic                           rd_en,
  output      logic [COL_BITS-1:0]            rd_addr,
  output      logic                           s1_valid_r,
  output      drd3_pkg::win_ctrl_t            s1_ctrl_r,
  output      logic [COL_BITS-1:0]            s1_addr_r,
  output      logic signed [SAMPLE_BITS-1:0]  s1_v_r,
  output      logic [drd3_pkg::THR_BITS-1:0]  threshold
);
  import drd3_pkg::*;

  localparam int ROW_BITS = $clog2(MAX_PLANE_HEIGHT + 2);

  logic [SIZE_BITS-1:0] line_width_r;
  logic [SIZE_BITS-1:0] plane_height_r;
  logic [THR_BITS-1:0]  threshold_r;
  logic [COL_BITS-1:0]  col_r, col_nxt;
  logic [ROW_BITS-1:0]  row_r, row_nxt;

  logic                          accept;
  logic                          cfg_accept;
  logic                          restart;
  logic [31:0]                   w32, h32, r32, c32;
  logic signed [SAMPLE_BITS-1:0] v_nxt;
  win_ctrl_t                     ctrl_nxt;

  assign accept        = in_bus.valid && in_bus.ready;
  assign cfg_accept    = cfg_bus.valid && cfg_bus.ready;
  assign in_bus.ready  = room;
  assign cfg_bus.ready = 1'b1;
  assign threshold     = threshold_r;

  // Sizes in use, clamped to 1..maximum.
  always_comb begin
    if (line_width_r == '0) begin
      w32 = 32'd1;
    end else if (32'(line_width_r) > 32'(MAX_LINE_WIDTH)) begin
      w32 = 32'(MAX_LINE_WIDTH);
    end else begin
      w32 = 32'(line_width_r);
    end
    if (plane_height_r == '0) begin
      h32 = 32'd1;
    end else if (32'(plane_height_r) > 32'(MAX_PLANE_HEIGHT)) begin
      h32 = 32'(MAX_PLANE_HEIGHT);
    end else begin
      h32 = 32'(plane_height_r);
    end
  end

  assign r32 = 32'(row_r);
  assign c32 = 32'(col_r);

  always_comb begin
    ctrl_nxt        = '0;
    ctrl_nxt.col0   = (c32 == 32'd0);
    ctrl_nxt.col1   = (c32 == 32'd1);
    ctrl_nxt.narrow = (w32 < 32'd2);
    ctrl_nxt.top_ok = (r32 >= 32'd2) && (r32 - 32'd2 < h32);
    ctrl_nxt.mid_ok = (r32 >= 32'd1) && (r32 - 32'd1 < h32);
    if (c32 == 32'd0) begin
      ctrl_nxt.emit = (r32 >= 32'd2);
      ctrl_nxt.eop  = (r32 >= 32'd2) && (r32 == h32 + 32'd1);
    end else begin
      ctrl_nxt.emit = (r32 >= 32'd1) && (r32 <= h32);
    end

    // Padding rows and flush ticks feed zero.
    if (r32 < h32 && in_bus.kind == KIND_SAMPLE) begin
      v_nxt = in_bus.sample;
    end else begin
      v_nxt = '0;
    end

    if (ctrl_nxt.eop || r32 > h32 + 32'd1) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (c32 + 32'd1 >= w32) begin
      col_nxt = '0;
      row_nxt = ROW_BITS'(r32 + 32'd1);
    end else begin
      col_nxt = COL_BITS'(c32 + 32'd1);
      row_nxt = row_r;
    end
  end

  assign rd_en   = accept;
  assign rd_addr = col_r;

  always_comb begin
    restart = 1'b0;
    if (cfg_accept) begin
      unique case (cfg_bus.index)
        REG_LINE_WIDTH:   restart = 1'b1;
        REG_PLANE_HEIGHT: restart = 1'b1;
        default:          restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RST;
      plane_height_r <= PLANE_HEIGHT_RST;
      threshold_r    <= THRESHOLD_RST;
      col_r          <= '0;
      row_r          <= '0;
      s1_valid_r     <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (cfg_accept) begin
        unique case (cfg_bus.index)
          REG_LINE_WIDTH:   line_width_r   <= cfg_bus.data[SIZE_BITS-1:0];
          REG_PLANE_HEIGHT: plane_height_r <= cfg_bus.data[SIZE_BITS-1:0];
          REG_THRESHOLD:    threshold_r    <= cfg_bus.data[THR_BITS-1:0];
          default:          ;
        endcase
      end
      if (restart) begin
        col_r <= '0;
        row_r <= '0;
      end else if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctrl_r <= ctrl_nxt;
      s1_addr_r <= col_r;
      s1_v_r    <= v_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/drd3_line_store.sv]
// Upper and middle line stores of the ridge detector, one memory each, with
// forwarding for a read that meets the write of the item just ahead.
// Depends on drd3_pkg.
`default_nettype none

module drd3_line_store #(
  parameter int MAX_LINE_WIDTH = drd3_pkg::MAX_LINE_WIDTH_DEF,
  parameter int SAMPLE_BITS    = drd3_pkg::SAMPLE_BITS_DEF,
  parameter int COL_BITS       = $clog2(MAX_LINE_WIDTH)
) (
  input  wire logic                           clk,
  input  wire logic                           rd_en,
  input  wire logic [COL_BITS-1:0]            rd_addr,
  input  wire logic                           wr_en,
  input  wire logic [COL_BITS-1:0]            wr_addr,
  input  wire logic signed [SAMPLE_BITS-1:0]  wr_v,
  output      logic signed [SAMPLE_BITS-1:0]  up_raw,
  output      logic signed [SAMPLE_BITS-1:0]  mid_raw
);
  import drd3_pkg::*;

  logic signed [SAMPLE_BITS-1:0] up_mem  [MAX_LINE_WIDTH];
  logic signed [SAMPLE_BITS-1:0] mid_mem [MAX_LINE_WIDTH];

  logic signed [SAMPLE_BITS-1:0] up_rd_r, mid_rd_r;
  logic signed [SAMPLE_BITS-1:0] fwd_up_r, fwd_mid_r;
  logic                          fwd_r;

  // With a one-pixel line, consecutive items share an address; the memory
  // returns the old word then, so the values being written are taken instead.
  assign up_raw  = fwd_r ? fwd_up_r  : up_rd_r;
  assign mid_raw = fwd_r ? fwd_mid_r : mid_rd_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_rd_r   <= up_mem[rd_addr];
      mid_rd_r  <= mid_mem[rd_addr];
      fwd_r     <= wr_en && (wr_addr == rd_addr);
      fwd_up_r  <= mid_raw;
      fwd_mid_r <= wr_v;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      up_mem[wr_addr]  <= mid_raw;
      mid_mem[wr_addr] <= wr_v;
    end
  end

endmodule

`default_nettype wire

[rtl/drd3_window.sv]
// 3x3 window columns and the directional ridge test for one centre.
// Depends on drd3_pkg.
`default_nettype none

module drd3_window #(
  parameter int SAMPLE_BITS = drd3_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           s1_valid,
  input  wire drd3_pkg::win_ctrl_t            s1_ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0]  s1_v,
  input  wire logic signed [SAMPLE_BITS-1:0]  up_raw,
  input  wire logic signed [SAMPLE_BITS-1:0]  mid_raw,
  input  wire logic [drd3_pkg::THR_BITS-1:0]  threshold,
  output      logic                           res_valid,
  output      logic signed [SAMPLE_BITS-1:0]  res_value,
  output      logic                           res_ridge,
  output      logic                           res_eop
);
  import drd3_pkg::*;

  localparam int SW   = SAMPLE_BITS + 2;
  localparam int CMPW = ((SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS) + 1;

  // Column registers: older (left) and newer (centre), rows top/mid/bottom.
  logic signed [SAMPLE_BITS-1:0] old_col_r [3];
  logic signed [SAMPLE_BITS-1:0] new_col_r [3];

  logic signed [SAMPLE_BITS-1:0] ntop, nmid;
  logic signed [SAMPLE_BITS-1:0] win [3][3];   // [column][row]
  logic signed [SW-1:0]          ex  [3][3];
  logic signed [CMPW-1:0]        centre_cmp, thr_cmp;
  logic signed [SW-1:0]          s_v, l_v, r_v;
  logic signed [SW-1:0]          s_h, l_h, r_h;
  logic signed [SW-1:0]          s_d45, l_d45, r_d45;
  logic signed [SW-1:0]          s_d135, l_d135, r_d135;
  logic                          ridge;

  assign ntop = s1_ctrl.top_ok ? up_raw  : '0;
  assign nmid = s1_ctrl.mid_ok ? mid_raw : '0;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win[0][k] = old_col_r[k];
      win[1][k] = new_col_r[k];
      win[2][k] = '0;
    end
    if (s1_ctrl.col0) begin
      // Column zero closes the previous row: the right column is outside.
      if (s1_ctrl.narrow) begin
        for (int k = 0; k < 3; k++) win[0][k] = '0;
      end
    end else begin
      if (s1_ctrl.col1) begin
        for (int k = 0; k < 3; k++) win[0][k] = '0;
      end
      win[2][0] = ntop;
      win[2][1] = nmid;
      win[2][2] = s1_v;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        ex[i][k] = {{2{win[i][k][SAMPLE_BITS-1]}}, win[i][k]};
      end
    end
  end

  // Each direction: centre line against its two parallel neighbour lines.
  always_comb begin
    s_v    = ex[1][0] + ex[1][1] + ex[1][2];
    l_v    = ex[0][0] + ex[0][1] + ex[0][2];
    r_v    = ex[2][0] + ex[2][1] + ex[2][2];
    s_h    = ex[0][1] + ex[1][1] + ex[2][1];
    l_h    = ex[0][0] + ex[1][0] + ex[2][0];
    r_h    = ex[0][2] + ex[1][2] + ex[2][2];
    s_d45  = ex[2][0] + ex[1][1] + ex[0][2];
    l_d45  = ex[0][0] + ex[1][0] + ex[0][1];
    r_d45  = ex[2][1] + ex[1][2] + ex[2][2];
    s_d135 = ex[0][0] + ex[1][1] + ex[2][2];
    l_d135 = ex[1][0] + ex[2][0] + ex[2][1];
    r_d135 = ex[0][1] + ex[0][2] + ex[1][2];
  end

  assign centre_cmp = {{(CMPW - SAMPLE_BITS){win[1][1][SAMPLE_BITS-1]}}, win[1][1]};
  assign thr_cmp    = {{(CMPW - THR_BITS){1'b0}}, threshold};

  assign ridge = (centre_cmp > thr_cmp) &&
                 (((l_v    < s_v)    && (s_v    > r_v))    ||
                  ((l_h    < s_h)    && (s_h    > r_h))    ||
                  ((l_d45  < s_d45)  && (s_d45  > r_d45))  ||
                  ((l_d135 < s_d135) && (s_d135 > r_d135)));

  assign res_valid = s1_valid && s1_ctrl.emit;
  assign res_ridge = ridge;
  assign res_value = ridge ? win[1][1] : '0;
  assign res_eop   = s1_ctrl.eop;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      for (int k = 0; k < 3; k++) old_col_r[k] <= new_col_r[k];
      new_col_r[0] <= ntop;
      new_col_r[1] <= nmid;
      new_col_r[2] <= s1_v;
    end
  end

endmodule

`default_nettype wire

[rtl/drd3_out_queue.sv]
// Small result queue that drives the output channel and absorbs receiver
// stalls. Depends on drd3_pkg and drd3_if.
`default_nettype none

module drd3_out_queue #(
  parameter int SAMPLE_BITS = drd3_pkg::SAMPLE_BITS_DEF,
  parameter int DEPTH       = drd3_pkg::OUT_QUEUE_DEPTH,
  parameter int CNT_BITS    = $clog2(DEPTH + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  input  wire logic signed [SAMPLE_BITS-1:0]  push_value,
  input  wire logic                           push_ridge,
  input  wire logic                           push_eop,
  output      logic [CNT_BITS-1:0]            count,
  drd3_out_if.source                          out_bus
);
  import drd3_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [SAMPLE_BITS-1:0] value_q [DEPTH];
  logic                          ridge_q [DEPTH];
  logic                          eop_q   [DEPTH];
  logic [PTR_BITS-1:0]           wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0]           count_r;
  logic                          pop;

  assign pop   = out_bus.valid && out_bus.ready;
  assign count = count_r;

  assign out_bus.valid        = (count_r != '0);
  assign out_bus.ridge_value  = value_q[rd_ptr_r];
  assign out_bus.is_ridge     = ridge_q[rd_ptr_r];
  assign out_bus.end_of_plane = eop_q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == DEPTH - 1) ? '0 : PTR_BITS'(32'(wr_ptr_r) + 1);
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == DEPTH - 1) ? '0 : PTR_BITS'(32'(rd_ptr_r) + 1);
      end
      if (push && !pop) begin
        count_r <= CNT_BITS'(32'(count_r) + 1);
      end else if (pop && !push) begin
        count_r <= CNT_BITS'(32'(count_r) - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      value_q[wr_ptr_r] <= push_value;
      ridge_q[wr_ptr_r] <= push_ridge;
      eop_q[wr_ptr_r]   <= push_eop;
    end
  end

endmodule

`default_nettype wire

[rtl/directional_ridge_detect_3x3_core.sv]
// Top level of the 3x3 directional ridge detector.
// Depends on drd3_pkg, drd3_if, drd3_ctrl, drd3_line_store, drd3_window
// and drd3_out_queue.
//
// Usage:
//   in_bus carries raster-order samples of one plane (kind 0) or flush ticks
//   (kind 1). After H*W samples, W+1 further transactions (flush ticks or
//   ignored samples) push out the last row; the plane then restarts.
//   out_bus delivers at most one result per input transaction, in order; the
//   last pixel of the plane carries end_of_plane.
//   cfg_bus writes line_width (0), plane_height (1) or ridge_threshold (2);
//   cfg_ready is always high. Writing a size restarts the plane. Writes must
//   be made only while no transaction is in flight; the block does not check.
// Timing:
//   One input transaction per cycle sustained while the queue has room. A
//   result is pushed into the output queue in the cycle after its input is
//   accepted and can be taken in the following cycle. The rate is set by the
//   line stores, which take one read and one write per cycle.
// Reset (synchronous, rst_n low): registers return to 200/200/41, the
//   position to the plane start, and the queue empties. No clearing pass is
//   run: line store reads are masked by the row position.
// Stalls: a four-entry result queue absorbs output backpressure; in_ready
//   drops only when the queue plus the item in flight would fill it.
`default_nettype none

module directional_ridge_detect_3x3_core #(
  parameter int MAX_LINE_WIDTH   = drd3_pkg::MAX_LINE_WIDTH_DEF,
  parameter int MAX_PLANE_HEIGHT = drd3_pkg::MAX_PLANE_HEIGHT_DEF,
  parameter int SAMPLE_BITS      = drd3_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  drd3_in_if.sink     in_bus,
  drd3_out_if.source  out_bus,
  drd3_cfg_if.sink    cfg_bus
);
  import drd3_pkg::*;

  localparam int COL_BITS = $clog2(MAX_LINE_WIDTH);
  localparam int CNT_BITS = $clog2(OUT_QUEUE_DEPTH + 1);

  logic                          room;
  logic                          rd_en;
  logic [COL_BITS-1:0]           rd_addr;
  logic                          s1_valid;
  win_ctrl_t                     s1_ctrl;
  logic [COL_BITS-1:0]           s1_addr;
  logic signed [SAMPLE_BITS-1:0] s1_v;
  logic [THR_BITS-1:0]           threshold;
  logic signed [SAMPLE_BITS-1:0] up_raw, mid_raw;
  logic                          res_valid;
  logic signed [SAMPLE_BITS-1:0] res_value;
  logic                          res_ridge;
  logic                          res_eop;
  logic [CNT_BITS-1:0]           q_count;

  // Reserve a queue slot for the transaction still in the window stage.
  assign room = (32'(q_count) + 32'(s1_valid)) < 32'(OUT_QUEUE_DEPTH);

  drd3_ctrl #(
    .MAX_LINE_WIDTH   (MAX_LINE_WIDTH),
    .MAX_PLANE_HEIGHT (MAX_PLANE_HEIGHT),
    .SAMPLE_BITS      (SAMPLE_BITS),
    .COL_BITS         (COL_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .cfg_bus    (cfg_bus),
    .room       (room),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .s1_valid_r (s1_valid),
    .s1_ctrl_r  (s1_ctrl),
    .s1_addr_r  (s1_addr),
    .s1_v_r     (s1_v),
    .threshold  (threshold)
  );

  drd3_line_store #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COL_BITS       (COL_BITS)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (s1_valid),
    .wr_addr (s1_addr),
    .wr_v    (s1_v),
    .up_raw  (up_raw),
    .mid_raw (mid_raw)
  );

  drd3_window #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk       (clk),
    .s1_valid  (s1_valid),
    .s1_ctrl   (s1_ctrl),
    .s1_v      (s1_v),
    .up_raw    (up_raw),
    .mid_raw   (mid_raw),
    .threshold (threshold),
    .res_valid (res_valid),
    .res_value (res_value),
    .res_ridge (res_ridge),
    .res_eop   (res_eop)
  );

  drd3_out_queue #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DEPTH       (OUT_QUEUE_DEPTH),
    .CNT_BITS    (CNT_BITS)
  ) u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_value (res_value),
    .push_ridge (res_ridge),
    .push_eop   (res_eop),
    .count      (q_count),
    .out_bus    (out_bus)
  );

endmodule

`default_nettype wire

[bench/tb_directional_ridge_detect_3x3_core.sv]
// Testbench for directional_ridge_detect_3x3_core: directed planes, then random
// planes of many sizes checked against an in-bench model of the ridge window.
// Depends on drd3_pkg, the drd3 channel interfaces and the core RTL.
`timescale 1ns / 1ps

module tb_directional_ridge_detect_3x3_core;
  import drd3_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

  localparam int MAX_W         = MAX_LINE_WIDTH_DEF;
  localparam int MAX_H         = MAX_PLANE_HEIGHT_DEF;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int PRINT_LIMIT   = 40;

  typedef struct packed {
    logic signed [15:0] ridge_value;
    logic               is_ridge;
    logic               end_of_plane;
  } ridge_result_t;

  logic clk = 1'b0;
  logic rst_n;

  always #10 clk = ~clk;

  drd3_in_if  in_bus ();
  drd3_out_if out_bus ();
  drd3_cfg_if cfg_bus ();

  directional_ridge_detect_3x3_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  // Mirror of the block's registers, position and pixel stores.
  int line_width_reg;
  int plane_height_reg;
  int threshold_reg;
  int col_pos;
  int row_pos;
  int upper_row_mem[MAX_W];
  int middle_row_mem[MAX_W];
  int win_cols[6];

  ridge_result_t pending_ridge_results[$];
  int mismatch_count = 0;
  int random_items = 0;
  bit calm = 1'b0;

  function automatic int clamp_size(input int value, input int hi);
    if (value < 1) return 1;
    if (value > hi) return hi;
    return value;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("%0t ns MISMATCH: %s", $time, what);
  endtask

  // Advances the mirrored state by one accepted item and queues the centre
  // result that the item completes, if any.
  task automatic predict_ridge_result(input logic kind, input logic signed [15:0] sample);
    int w, h, r, c, v, ntop, nmid, s;
    int a, a1, a2, a3, a4, a5, a6, a7, a8;
    bit emit, eop, rid;
    ridge_result_t res;
    begin
      w = clamp_size(line_width_reg, MAX_W);
      h = clamp_size(plane_height_reg, MAX_H);
      r = row_pos;
      c = col_pos;
      if (c >= w) c = w - 1;
      v = (r < h && kind == KIND_SAMPLE) ? int'(sample) : 0;
      ntop = (r >= 2 && r - 2 < h) ? upper_row_mem[c] : 0;
      nmid = (r >= 1 && r - 1 < h) ? middle_row_mem[c] : 0;

      a1 = win_cols[0]; a4 = win_cols[1]; a6 = win_cols[2];
      a2 = win_cols[3]; a  = win_cols[4]; a7 = win_cols[5];
      a3 = 0; a5 = 0; a8 = 0;
      emit = 1'b0;
      eop = 1'b0;
      if (c == 0) begin
        // Column zero closes the last centre of the row above.
        if (r >= 2) begin
          emit = 1'b1;
          eop = (r == h + 1);
          if (w < 2) begin
            a1 = 0; a4 = 0; a6 = 0;
          end
        end
      end else if (r >= 1 && r <= h) begin
        emit = 1'b1;
        if (c == 1) begin
          a1 = 0; a4 = 0; a6 = 0;
        end
        a3 = ntop; a5 = nmid; a8 = v;
      end

      if (emit) begin
        rid = 1'b0;
        if (a > threshold_reg) begin
          s = a2 + a + a7;
          if (a1 + a4 + a6 < s && s > a3 + a5 + a8) rid = 1'b1;
          s = a4 + a + a5;
          if (a1 + a2 + a3 < s && s > a6 + a7 + a8) rid = 1'b1;
          s = a3 + a + a6;
          if (a1 + a2 + a4 < s && s > a5 + a7 + a8) rid = 1'b1;
          s = a1 + a + a8;
          if (a2 + a3 + a5 < s && s > a4 + a6 + a7) rid = 1'b1;
        end
        res.ridge_value = rid ? a[15:0] : 16'sd0;
        res.is_ridge = rid;
        res.end_of_plane = eop;
        pending_ridge_results = {pending_ridge_results, res};
      end

      win_cols[0] = win_cols[3];
      win_cols[1] = win_cols[4];
      win_cols[2] = win_cols[5];
      win_cols[3] = ntop;
      win_cols[4] = nmid;
      win_cols[5] = v;
      upper_row_mem[c] = middle_row_mem[c];
      middle_row_mem[c] = v;

      if (eop || r > h + 1) begin
        row_pos = 0;
        col_pos = 0;
      end else if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = r + 1;
      end else begin
        col_pos = c + 1;
      end
    end
  endtask

  task automatic send_item(input logic kind, input logic signed [15:0] sample);
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.kind   <= kind;
    in_bus.sample <= sample;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    predict_ridge_result(kind, sample);
  endtask

  // Stops the input and lets the block settle so that a register write is safe.
  task automatic wait_idle;
    in_bus.valid <= 1'b0;
    while (pending_ridge_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                input logic [CFG_DATA_BITS-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= data;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    case (index)
      REG_LINE_WIDTH: begin
        line_width_reg = int'(data[SIZE_BITS-1:0]);
        col_pos = 0;
        row_pos = 0;
      end
      REG_PLANE_HEIGHT: begin
        plane_height_reg = int'(data[SIZE_BITS-1:0]);
        col_pos = 0;
        row_pos = 0;
      end
      REG_THRESHOLD: threshold_reg = int'(data[THR_BITS-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Sends items first..last-1 of one plane: pixels, then the padding row and
  // the closing item. Padding carries random kinds and values.
  task automatic send_plane_items(input int first, input int last, input bit wide_values);
    int w, h, n, t;
    logic kind;
    logic signed [15:0] sample;
    begin
      w = clamp_size(line_width_reg, MAX_W);
      h = clamp_size(plane_height_reg, MAX_H);
      for (n = first; n < last; n++) begin
        if (n < h * w) begin
          kind = ($urandom_range(0, 99) < 4) ? KIND_FLUSH : KIND_SAMPLE;
          t = $urandom_range(0, 700);
          sample = wide_values ? 16'($urandom) : 16'(t - 150);
        end else begin
          kind = ($urandom_range(0, 1) == 1) ? KIND_FLUSH : KIND_SAMPLE;
          sample = 16'($urandom);
        end
        send_item(kind, sample);
        random_items++;
      end
    end
  endtask

  task automatic test_single_pixel_plane;
    write_register(REG_LINE_WIDTH, 15'd0);
    write_register(REG_PLANE_HEIGHT, 15'd0);
    send_item(KIND_SAMPLE, 16'sh7FFF);
    send_item(KIND_FLUSH, 16'sd0);
    send_item(KIND_SAMPLE, -16'sd5);
    wait_idle;
  endtask

  task automatic test_sample_extremes;
    write_register(REG_LINE_WIDTH, 15'd3);
    write_register(REG_PLANE_HEIGHT, 15'd1);
    write_register(REG_THRESHOLD, 15'd0);
    send_item(KIND_SAMPLE, 16'sh8000);
    send_item(KIND_SAMPLE, 16'sh7FFF);
    send_item(KIND_SAMPLE, -16'sd1);
    // Samples in the padding row must be taken as zero.
    send_item(KIND_SAMPLE, 16'sd100);
    send_item(KIND_FLUSH, 16'sd0);
    send_item(KIND_FLUSH, 16'sh7FFF);
    send_item(KIND_SAMPLE, 16'sd7);
    wait_idle;
  endtask

  task automatic test_threshold_update;
    write_register(REG_LINE_WIDTH, 15'd2);
    write_register(REG_PLANE_HEIGHT, 15'd2);
    write_register(REG_THRESHOLD, 15'h7FFF);
    send_item(KIND_SAMPLE, 16'sd300);
    send_item(KIND_FLUSH, 16'sh7FFF);
    wait_idle;
    // A threshold change keeps the position within the plane.
    write_register(REG_THRESHOLD, 15'd41);
    send_item(KIND_SAMPLE, 16'sd200);
    send_item(KIND_SAMPLE, -16'sd7);
    send_item(KIND_FLUSH, 16'sd0);
    send_item(KIND_FLUSH, 16'sd0);
    send_item(KIND_FLUSH, 16'sd0);
    wait_idle;
  endtask

  task automatic test_size_restart;
    write_register(REG_LINE_WIDTH, 15'd2047);
    write_register(REG_PLANE_HEIGHT, 15'd2047);
    send_item(KIND_SAMPLE, 16'($urandom));
    send_item(KIND_SAMPLE, 16'($urandom));
    send_item(KIND_FLUSH, 16'($urandom));
    wait_idle;
    write_register(REG_UNUSED, 15'h7FFF);
    write_register(REG_LINE_WIDTH, 15'd2);
    write_register(REG_PLANE_HEIGHT, 15'd1);
    send_item(KIND_SAMPLE, 16'sd500);
    send_item(KIND_SAMPLE, 16'sd20);
    send_item(KIND_FLUSH, 16'sd0);
    send_item(KIND_SAMPLE, -16'sd1);
    send_item(KIND_FLUSH, 16'sd0);
    wait_idle;
  endtask

  task automatic test_random_planes;
    int phase, planes, p, total, split, w, h, roll;
    logic [CFG_DATA_BITS-1:0] wdata, hdata, tdata;
    bit wide_values;
    begin
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
        calm = (phase >= 3 && phase <= 5);
        wdata = 15'($urandom_range(1, 10));
        hdata = 15'($urandom_range(1, 8));
        if ($urandom_range(0, 9) == 0) wdata = 15'd0;
        if ($urandom_range(0, 9) == 0) hdata = 15'd0;
        // Bits above the size field are dropped by the block.
        if ($urandom_range(0, 9) == 0) wdata[14:11] = 4'($urandom);
        if ($urandom_range(0, 9) == 0) hdata[14:11] = 4'($urandom);
        if (phase == 2) begin
          wdata = 15'd1;
          hdata = 15'd2047;
        end
        if (phase == 6) begin
          wdata = 15'd2047;
          hdata = 15'd1;
        end
        roll = $urandom_range(0, 99);
        if (roll < 70) tdata = 15'($urandom_range(0, 150));
        else if (roll < 85) tdata = 15'($urandom);
        else tdata = ($urandom_range(0, 1) == 1) ? 15'h7FFF : 15'd0;
        wide_values = ($urandom_range(0, 3) == 0);

        wait_idle;
        write_register(REG_LINE_WIDTH, wdata);
        write_register(REG_PLANE_HEIGHT, hdata);
        write_register(REG_THRESHOLD, tdata);

        w = clamp_size(line_width_reg, MAX_W);
        h = clamp_size(plane_height_reg, MAX_H);
        total = h * w + w + 1;
        if (phase == 6) begin
          // Widest rows: only a short partial plane, then a restart.
          send_plane_items(0, 40, 1'b1);
        end else begin
          planes = (phase == 2) ? 1 : $urandom_range(1, 3);
          for (p = 0; p < planes; p++) begin
            roll = $urandom_range(0, 99);
            split = $urandom_range(1, total - 1);
            if (roll < 15) begin
              send_plane_items(0, split, wide_values);
              wait_idle;
              write_register(REG_THRESHOLD, 15'($urandom_range(0, 150)));
              send_plane_items(split, total, wide_values);
            end else if (roll < 25) begin
              // Abandoned plane; the next size write restarts it.
              send_plane_items(0, split, wide_values);
              break;
            end else begin
              send_plane_items(0, total, wide_values);
            end
          end
        end
        phase++;
      end
      calm = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    ridge_result_t want;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_ridge_results.size() == 0) begin
        report_mismatch("result transaction with no expected result");
      end else begin
        want = pending_ridge_results.pop_front();
        if (out_bus.ridge_value !== want.ridge_value)
          report_mismatch($sformatf("ridge_value %0d, expected %0d",
                                    out_bus.ridge_value, want.ridge_value));
        if (out_bus.is_ridge !== want.is_ridge)
          report_mismatch($sformatf("is_ridge %b, expected %b",
                                    out_bus.is_ridge, want.is_ridge));
        if (out_bus.end_of_plane !== want.end_of_plane)
          report_mismatch($sformatf("end_of_plane %b, expected %b",
                                    out_bus.end_of_plane, want.end_of_plane));
      end
    end
  end

  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= calm || ($urandom_range(0, 99) >= 15);
    end
  end

  initial begin
    #4000000;
    $display("tb_directional_ridge_detect_3x3_core failed");
    $finish;
  end

  initial begin
    int i;
    rst_n         <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.kind   <= KIND_SAMPLE;
    in_bus.sample <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_LINE_WIDTH;
    cfg_bus.data  <= '0;

    line_width_reg   = int'(LINE_WIDTH_RST);
    plane_height_reg = int'(PLANE_HEIGHT_RST);
    threshold_reg    = int'(THRESHOLD_RST);
    col_pos = 0;
    row_pos = 0;
    for (i = 0; i < MAX_W; i++) begin
      upper_row_mem[i] = 0;
      middle_row_mem[i] = 0;
    end
    for (i = 0; i < 6; i++) win_cols[i] = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_pixel_plane;
    test_sample_extremes;
    test_threshold_update;
    test_size_restart;
    test_random_planes;
    wait_idle;

    if (mismatch_count == 0) begin
      $display("tb_directional_ridge_detect_3x3_core passed");
    end else begin
      $display("tb_directional_ridge_detect_3x3_core failed");
    end
    $finish;
  end

endmodule
